// File: design/fpn_pkg.sv
`default_nettype none
package fpn_pkg;

	// permutation table geometry
	localparam int TBL_AW = 8;
	localparam int TBL_DW = 8;
	localparam int TBL_DEPTH = 1 << TBL_AW;

	// field widths
	localparam int CFG_W = 4;
	localparam int VOXEL_W = 10;
	localparam int TEXEL_W = 8;
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// register indexes
	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_DEPTH = 3'd2;
	localparam logic [2:0] REG_SCALE = 3'd3;
	localparam logic [2:0] REG_OCTAVES = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] RST_DIM_LOG2 = 4'd7;
	localparam logic [CFG_W-1:0] RST_SCALE = 4'd4;
	localparam logic [CFG_W-1:0] RST_OCTAVES = 4'd6;

	// fade polynomial 6t^5 - 15t^4 + 10t^3
	localparam int FADE_C6 = 6;
	localparam int FADE_C15 = 15;
	localparam int FADE_C10 = 10;

	// gradient hash decode
	localparam logic [3:0] GRAD_U_Y = 4'd8;
	localparam logic [3:0] GRAD_V_Y = 4'd4;
	localparam logic [3:0] GRAD_V_X0 = 4'd12;
	localparam logic [3:0] GRAD_V_X1 = 4'd14;

	// output quantization
	localparam int QUANT_MAX = 255;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// File: design/fractal_perlin_noise_texel.sv
`default_nettype none
// table write: stored into the permutation table, no result
// evaluate: per octave, a stepped schedule of table reads, fades, gradients
//   and lerps, then two serial divisions (remainder, then scaled quotient)
//   before the texel is registered and out_valid rises
// one item in flight; the next request is taken once the result is registered
// reset clears control and config registers; the permutation table is not cleared
module fractal_perlin_noise_texel #(
	parameter int MAX_DIM_LOG2 = 10,
	parameter int FRAC_BITS = 16,
	parameter int MAX_OCTAVES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         operation,
	input  wire logic [fpn_pkg::TBL_AW-1:0]   table_index,
	input  wire logic [fpn_pkg::TBL_DW-1:0]   table_value,
	input  wire logic [fpn_pkg::VOXEL_W-1:0]  voxel_x,
	input  wire logic [fpn_pkg::VOXEL_W-1:0]  voxel_y,
	input  wire logic [fpn_pkg::VOXEL_W-1:0]  voxel_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [fpn_pkg::TEXEL_W-1:0]  texel,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [fpn_pkg::APB_AW-1:0]   paddr,
	input  wire logic [fpn_pkg::APB_DW-1:0]   pwdata,
	output logic      [fpn_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);
	import fpn_pkg::*;

	localparam int CW = FRAC_BITS + TBL_AW;
	localparam int DW = FRAC_BITS + 6;
	localparam int SW = DW + MAX_OCTAVES + 2;
	localparam int VW = MAX_OCTAVES + 1;
	localparam int VSW = VOXEL_W + CFG_W;
	localparam logic signed [DW-1:0] QONE = DW'(1) <<< FRAC_BITS;
	localparam logic signed [DW-1:0] Q15 = DW'(FADE_C15) <<< FRAC_BITS;
	localparam logic signed [DW-1:0] Q10 = DW'(FADE_C10) <<< FRAC_BITS;
	localparam logic signed [DW-1:0] C6 = DW'(FADE_C6);
	localparam logic [4:0] STEP_FADE_END = 5'd12;
	localparam logic [4:0] STEP_LAST = 5'd23;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_OCT  = 6'b000010,
		ST_PREP = 6'b000100,
		ST_MOD  = 6'b001000,
		ST_QUO  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic [CFG_W-1:0] oct_q, n_q;
	logic [CFG_W-1:0] width_q, height_q, depth_q, scale_q, octaves_q;
	logic [CW-1:0] cx_q, cy_q, cz_q;
	logic signed [SW-1:0] s_q;
	logic [TBL_AW-1:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [DW-1:0] g_q [8];
	logic signed [DW-1:0] fd_q [3];
	logic signed [DW-1:0] t3_q, la_q, lb_q, lc_q, ld_q, l0_q, l1_q;
	logic [VW-1:0] den_q;
	logic neg_q;
	logic [TEXEL_W-1:0] res_q, texel_q;
	logic out_valid_q;

	logic in_accept, cfg_write, out_free;
	logic [TBL_AW-1:0] raddr, rdata;
	logic signed [DW-1:0] xf, yf, zf, x1, y1, z1, tv, mul_a, mul_b, prod, nval;
	logic [2:0] corner;
	logic [2:0] gidx;
	logic signed [DW-1:0] gval;
	logic [1:0] axis;
	logic div_start;
	logic [SW-1:0] div_dividend, div_quot;
	logic [VW-1:0] div_rem, den_n, r_fix;
	div_stat_t div_stat;
	logic [CFG_W-1:0] n_clamp;
	logic signed [SW-1:0] m_val;
	logic [VW:0] pow_n1;

	function automatic logic [CW-1:0] scale_coord(input logic [VOXEL_W-1:0] vox,
		input logic [CFG_W-1:0] lg, input logic [CFG_W-1:0] sc);
		logic [CFG_W-1:0] l;
		logic [VSW-1:0] vs;
		logic [VSW+FRAC_BITS-1:0] full;
		l = (lg > CFG_W'(MAX_DIM_LOG2)) ? CFG_W'(MAX_DIM_LOG2) : lg;
		vs = VSW'(vox) * VSW'(sc);
		full = {vs, {FRAC_BITS{1'b0}}} >> l;
		return full[CW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] grad(input logic [3:0] h,
		input logic signed [DW-1:0] gx, input logic signed [DW-1:0] gy,
		input logic signed [DW-1:0] gz);
		logic signed [DW-1:0] gu, gv;
		gu = (h < GRAD_U_Y) ? gx : gy;
		if (h < GRAD_V_Y) begin
			gv = gy;
		end else if (h == GRAD_V_X0 || h == GRAD_V_X1) begin
			gv = gx;
		end else begin
			gv = gz;
		end
		return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
	endfunction

	// handshakes
	assign in_stall = state_q != ST_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign out_valid = out_valid_q;
	assign texel = texel_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_DIM_LOG2;
			height_q <= RST_DIM_LOG2;
			depth_q <= RST_DIM_LOG2;
			scale_q <= RST_SCALE;
			octaves_q <= RST_OCTAVES;
		end else if (cfg_write) begin
			case (paddr[4:2])
				REG_WIDTH: width_q <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_DEPTH: depth_q <= pwdata[CFG_W-1:0];
				REG_SCALE: scale_q <= pwdata[CFG_W-1:0];
				REG_OCTAVES: octaves_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			REG_WIDTH: prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_DEPTH: prdata = APB_DW'(depth_q);
			REG_SCALE: prdata = APB_DW'(scale_q);
			REG_OCTAVES: prdata = APB_DW'(octaves_q);
			default: prdata = '0;
		endcase
	end

	// cell fractions of the current octave
	assign xf = DW'({1'b0, cx_q[FRAC_BITS-1:0]});
	assign yf = DW'({1'b0, cy_q[FRAC_BITS-1:0]});
	assign zf = DW'({1'b0, cz_q[FRAC_BITS-1:0]});
	assign x1 = xf - QONE;
	assign y1 = yf - QONE;
	assign z1 = zf - QONE;

	// table read address per step
	always_comb begin
		case (step_q)
			5'd0: raddr = cx_q[CW-1:FRAC_BITS];
			5'd1: raddr = cx_q[CW-1:FRAC_BITS] + 1'b1;
			5'd2: raddr = a_q;
			5'd3: raddr = a_q + 1'b1;
			5'd4: raddr = b_q;
			5'd5: raddr = b_q + 1'b1;
			5'd6: raddr = aa_q;
			5'd7: raddr = aa_q + 1'b1;
			5'd8: raddr = ba_q;
			5'd9: raddr = ba_q + 1'b1;
			5'd10: raddr = ab_q;
			5'd11: raddr = ab_q + 1'b1;
			5'd12: raddr = bb_q;
			5'd13: raddr = bb_q + 1'b1;
			default: raddr = cx_q[CW-1:FRAC_BITS];
		endcase
	end

	fpn_perm_mem u_mem (
		.clk   (clk),
		.we    (in_accept && operation == OP_WRITE),
		.waddr (table_index),
		.wdata (table_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// corner gradient from the hash read back this cycle
	assign corner = 3'(step_q - 5'd7);
	assign gidx = {corner[0], corner[2], corner[1]};
	assign gval = grad(rdata[3:0], corner[1] ? x1 : xf, corner[2] ? y1 : yf,
		corner[0] ? z1 : zf);

	// multiplier operands: fades first, then the lerp tree
	assign axis = step_q[3:2];
	always_comb begin
		case (axis)
			2'd0: tv = xf;
			2'd1: tv = yf;
			default: tv = zf;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (step_q < STEP_FADE_END) begin
			case (step_q[1:0])
				2'd0: begin
					mul_a = tv;
					mul_b = tv;
				end
				2'd1: begin
					mul_a = prod;
					mul_b = tv;
				end
				2'd2: begin
					mul_a = tv;
					mul_b = C6 * tv - Q15;
				end
				default: begin
					mul_a = t3_q;
					mul_b = prod + Q10;
				end
			endcase
		end else begin
			case (step_q)
				5'd15: begin
					mul_a = fd_q[0];
					mul_b = g_q[1] - g_q[0];
				end
				5'd16: begin
					mul_a = fd_q[0];
					mul_b = g_q[3] - g_q[2];
				end
				5'd17: begin
					mul_a = fd_q[0];
					mul_b = g_q[5] - g_q[4];
				end
				5'd18: begin
					mul_a = fd_q[0];
					mul_b = g_q[7] - g_q[6];
				end
				5'd19: begin
					mul_a = fd_q[1];
					mul_b = lb_q - la_q;
				end
				5'd20: begin
					mul_a = fd_q[1];
					mul_b = ld_q - lc_q;
				end
				5'd22: begin
					mul_a = fd_q[2];
					mul_b = l1_q - l0_q;
				end
				default: ;
			endcase
		end
	end

	fpn_mul #(.W(DW), .FB(FRAC_BITS)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign nval = l0_q + prod;

	// octave datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_OCT) begin
			case (step_q)
				5'd1: a_q <= rdata + cy_q[CW-1:FRAC_BITS];
				5'd2: b_q <= rdata + cy_q[CW-1:FRAC_BITS];
				5'd3: aa_q <= rdata + cz_q[CW-1:FRAC_BITS];
				5'd4: ab_q <= rdata + cz_q[CW-1:FRAC_BITS];
				5'd5: ba_q <= rdata + cz_q[CW-1:FRAC_BITS];
				5'd6: bb_q <= rdata + cz_q[CW-1:FRAC_BITS];
				5'd16: la_q <= g_q[0] + prod;
				5'd17: lb_q <= g_q[2] + prod;
				5'd18: lc_q <= g_q[4] + prod;
				5'd19: ld_q <= g_q[6] + prod;
				5'd20: l0_q <= la_q + prod;
				5'd21: l1_q <= lc_q + prod;
				default: ;
			endcase
			if (step_q >= 5'd7 && step_q <= 5'd14) begin
				g_q[gidx] <= gval;
			end
			if (step_q < STEP_FADE_END && step_q[1:0] == 2'd2) begin
				t3_q <= prod;
			end
			if (step_q == 5'd4 || step_q == 5'd8 || step_q == 5'd12) begin
				fd_q[2'(axis - 2'd1)] <= prod;
			end
		end
	end

	// normalization and divider setup
	assign m_val = s_q + (SW'(SW'(1) << n_q) - SW'(1) << FRAC_BITS);
	assign pow_n1 = (VW+1)'(1) << (n_q + 1'b1);
	assign den_n = VW'(pow_n1 - (VW+1)'(2));
	assign r_fix = (neg_q && div_rem != '0) ? den_q - div_rem : div_rem;
	assign n_clamp = (octaves_q == '0) ? CFG_W'(1) :
		(octaves_q > CFG_W'(MAX_OCTAVES)) ? CFG_W'(MAX_OCTAVES) : octaves_q;

	always_comb begin
		div_start = 1'b0;
		div_dividend = '0;
		if (state_q == ST_PREP) begin
			div_start = 1'b1;
			div_dividend = m_val[SW-1] ? SW'(-m_val) : SW'(m_val);
		end else if (state_q == ST_MOD && div_stat.done) begin
			div_start = 1'b1;
			div_dividend = SW'(r_fix) * SW'(QUANT_MAX);
		end
	end

	fpn_div #(.NW(SW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  ((state_q == ST_PREP) ? den_n : den_q),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// coordinates, sum and result payload
	always_ff @(posedge clk) begin
		if (in_accept && operation == OP_EVAL) begin
			cx_q <= scale_coord(voxel_x, width_q, scale_q);
			cy_q <= scale_coord(voxel_y, height_q, scale_q);
			cz_q <= scale_coord(voxel_z, depth_q, scale_q);
			n_q <= n_clamp;
			s_q <= '0;
		end else if (state_q == ST_OCT && step_q == STEP_LAST) begin
			cx_q <= cx_q << 1;
			cy_q <= cy_q << 1;
			cz_q <= cz_q << 1;
			s_q <= (s_q <<< 1) + SW'(nval);
		end
		if (state_q == ST_PREP) begin
			den_q <= den_n;
			neg_q <= m_val[SW-1];
		end
		if (state_q == ST_QUO && div_stat.done) begin
			res_q <= div_quot[TEXEL_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			texel_q <= res_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			oct_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && operation == OP_EVAL) begin
						state_q <= ST_OCT;
						step_q <= '0;
						oct_q <= n_clamp;
					end
				end
				ST_OCT: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						if (oct_q == CFG_W'(1)) begin
							state_q <= ST_PREP;
						end else begin
							oct_q <= oct_q - 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_PREP: state_q <= ST_MOD;
				ST_MOD: begin
					if (div_stat.done) begin
						state_q <= ST_QUO;
					end
				end
				ST_QUO: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result appears only out of the final state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	// the divider is never restarted mid-division
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// the octave schedule stays in range
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OCT |-> (step_q <= STEP_LAST && oct_q != '0))
		else $error("octave sequencer out of range");

	// a finished division is consumed by the sequencer
	a_done_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_MOD || state_q == ST_QUO))
		else $error("division result dropped");
`endif

endmodule
`default_nettype wire

// File: design/fpn_perm_mem.sv
`default_nettype none
module fpn_perm_mem (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [fpn_pkg::TBL_AW-1:0] waddr,
	input  wire logic [fpn_pkg::TBL_DW-1:0] wdata,
	input  wire logic [fpn_pkg::TBL_AW-1:0] raddr,
	output logic      [fpn_pkg::TBL_DW-1:0] rdata
);
	import fpn_pkg::*;

	logic [TBL_DW-1:0] mem_q [TBL_DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: design/fpn_mul.sv
`default_nettype none
module fpn_mul #(
	parameter int W = 22,
	parameter int FB = 16
) (
	input  wire logic                clk,
	input  wire logic signed [W-1:0] a,
	input  wire logic signed [W-1:0] b,
	output logic signed      [W-1:0] p
);
	import fpn_pkg::*;

	logic signed [2*W-1:0] full;

	assign full = a * b;

	// floor of the fixed-point product
	always_ff @(posedge clk) begin
		p <= full[FB +: W];
	end

endmodule
`default_nettype wire

// File: design/fpn_div.sv
`default_nettype none
module fpn_div #(
	parameter int NW = 32,
	parameter int VW = 9
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NW-1:0]   dividend,
	input  wire logic [VW-1:0]   divisor,
	output fpn_pkg::div_stat_t   stat,
	output logic      [NW-1:0]   quot,
	output logic      [VW-1:0]   rem
);
	import fpn_pkg::*;

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   n_q;
	logic [VW-1:0]   r_q;
	logic [VW-1:0]   dv_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [VW:0]     trial;
	logic            ge;

	// one quotient bit per cycle
	assign trial = {r_q, n_q[NW-1]};
	assign ge = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && cnt_q == CNTW'(1);
			if (start) begin
				cnt_q <= CNTW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// restoring shift-subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			dv_q <= divisor;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[NW-2:0], ge};
			r_q <= ge ? VW'(trial - {1'b0, dv_q}) : trial[VW-1:0];
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;
	assign quot = n_q;
	assign rem = r_q;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import fpn_pkg::*;

	localparam int QB = 16;
	localparam int OCT_MAX = 8;
	localparam int DIM_MAX = 10;
	localparam int WATCHDOG = 20000;
	localparam int GROUP_ITEMS = 90;
	localparam longint QONE = 64'sd1 << QB;

	// request as queued by the stimulus
	typedef struct packed {
		logic                op;
		logic [TBL_AW-1:0]   idx;
		logic [TBL_DW-1:0]   val;
		logic [VOXEL_W-1:0]  vx;
		logic [VOXEL_W-1:0]  vy;
		logic [VOXEL_W-1:0]  vz;
	} noise_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_WRITE;
	logic [TBL_AW-1:0] table_index = '0;
	logic [TBL_DW-1:0] table_value = '0;
	logic [VOXEL_W-1:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TEXEL_W-1:0] texel;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	fractal_perlin_noise_texel u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .table_index(table_index), .table_value(table_value),
		.voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
		.out_valid(out_valid), .out_stall(out_stall), .texel(texel),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [7:0] perm [TBL_DEPTH];
	logic [3:0] dim_lg [3];
	logic [3:0] scale_r, oct_r;

	noise_req_t pending_reqs [$];
	logic [TEXEL_W-1:0] expected_texels [$];
	logic [TEXEL_W-1:0] want_texel;
	int mismatches = 0;
	int texels_seen = 0;
	int writes_sent = 0, evals_sent = 0, cfg_groups = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int quiet_cycles = 0;

	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> QB;
	endfunction

	function automatic longint fade(longint t);
		longint t3, poly;
		t3 = qmul(qmul(t, t), t);
		poly = qmul(t, FADE_C6 * t - FADE_C15 * QONE) + FADE_C10 * QONE;
		return qmul(t3, poly);
	endfunction

	function automatic longint lerp(longint t, longint a, longint b);
		return a + qmul(t, b - a);
	endfunction

	function automatic longint grad(logic [7:0] hv, longint x, longint y, longint z);
		logic [3:0] h;
		longint u, v;
		h = hv[3:0];
		u = (h < GRAD_U_Y) ? x : y;
		v = (h < GRAD_V_Y) ? y : ((h == GRAD_V_X0 || h == GRAD_V_X1) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic [7:0] pg(int i);
		return perm[i & 8'hff];
	endfunction

	function automatic longint octave_value(longint cx, longint cy, longint cz);
		int xi, yi, zi, a, aa, ab, b, ba, bb;
		longint x, y, z, x1, y1, z1, u, v, w, l0, l1;
		xi = int'(cx >> QB) & 255; yi = int'(cy >> QB) & 255; zi = int'(cz >> QB) & 255;
		x = cx & (QONE - 1); y = cy & (QONE - 1); z = cz & (QONE - 1);
		u = fade(x); v = fade(y); w = fade(z);
		a = pg(xi) + yi; aa = pg(a) + zi; ab = pg(a + 1) + zi;
		b = pg(xi + 1) + yi; ba = pg(b) + zi; bb = pg(b + 1) + zi;
		x1 = x - QONE; y1 = y - QONE; z1 = z - QONE;
		l0 = lerp(v, lerp(u, grad(pg(aa), x, y, z), grad(pg(ba), x1, y, z)),
			lerp(u, grad(pg(ab), x, y1, z), grad(pg(bb), x1, y1, z)));
		l1 = lerp(v, lerp(u, grad(pg(aa + 1), x, y, z1), grad(pg(ba + 1), x1, y, z1)),
			lerp(u, grad(pg(ab + 1), x, y1, z1), grad(pg(bb + 1), x1, y1, z1)));
		return lerp(w, l0, l1);
	endfunction

	function automatic longint scaled(logic [VOXEL_W-1:0] vox, logic [3:0] lg);
		int l;
		l = (lg > DIM_MAX) ? DIM_MAX : lg;
		return ((longint'(vox) * scale_r) << QB) >>> l;
	endfunction

	// random request, unused fields filled with noise
	function automatic noise_req_t rand_req(bit wr);
		noise_req_t r;
		r.op = wr ? OP_WRITE : OP_EVAL;
		r.idx = TBL_AW'($urandom_range(TBL_DEPTH - 1));
		r.val = TBL_DW'($urandom_range(255));
		r.vx = VOXEL_W'($urandom_range(1023));
		r.vy = VOXEL_W'($urandom_range(1023));
		r.vz = VOXEL_W'($urandom_range(1023));
		return r;
	endfunction

	// apply a request to the predictor
	task automatic predict_request(noise_req_t r);
		int n;
		longint bx, by, bz, s, k, den, m, rm;
		if (r.op == OP_WRITE) begin
			perm[r.idx] = r.val;
			return;
		end
		n = (oct_r == 0) ? 1 : ((oct_r > OCT_MAX) ? OCT_MAX : oct_r);
		bx = scaled(r.vx, dim_lg[0]); by = scaled(r.vy, dim_lg[1]);
		bz = scaled(r.vz, dim_lg[2]);
		s = 0;
		for (int i = 0; i < n; i++)
			s += octave_value(bx << i, by << i, bz << i) * (64'sd1 << (n - 1 - i));
		k = (64'sd1 << n) - 1;
		den = 2 * k;
		m = s + k * QONE;
		rm = m % den;
		if (rm < 0) rm += den;
		expected_texels.push_back(TEXEL_W'((QUANT_MAX * rm) / den));
	endtask

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("%s mismatch after %0d texels: got %0d expected %0d",
			what, texels_seen, got, want);
	endtask

	// config write with setup and access cycles
	task automatic apb_write(logic [2:0] idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH: dim_lg[0] = v;
			REG_HEIGHT: dim_lg[1] = v;
			REG_DEPTH: dim_lg[2] = v;
			REG_SCALE: scale_r = v;
			REG_OCTAVES: oct_r = v;
			default: ;
		endcase
	endtask

	// config read compared against the written value
	task automatic apb_check(logic [2:0] idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_AW'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DW'(v))
			report_mismatch("register", int'(prdata), int'(v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every request is taken and every result is out
	task automatic wait_drain();
		while (!(pending_reqs.size() == 0 && !in_valid && expected_texels.size() == 0))
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!(in_valid && in_stall)) begin
				if (in_valid) predict_request(pending_reqs.pop_front());
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					operation <= pending_reqs[0].op;
					table_index <= pending_reqs[0].idx;
					table_value <= pending_reqs[0].val;
					voxel_x <= pending_reqs[0].vx;
					voxel_y <= pending_reqs[0].vy;
					voxel_z <= pending_reqs[0].vz;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				texels_seen++;
				if (expected_texels.size() == 0) begin
					report_mismatch("unexpected", texel, -1);
				end else begin
					want_texel = expected_texels.pop_front();
					if (texel !== want_texel)
						report_mismatch("texel", texel, want_texel);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WATCHDOG) begin
				$display("watchdog expired with %0d results outstanding",
					expected_texels.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		noise_req_t r;
		logic [7:0] shuf [TBL_DEPTH];
		logic [7:0] tmp;
		logic [CFG_W-1:0] wl, hl, dl, sc, oc;
		int j;
		bit wr;

		for (int i = 0; i < TBL_DEPTH; i++) perm[i] = '0;
		dim_lg[0] = RST_DIM_LOG2;
		dim_lg[1] = RST_DIM_LOG2;
		dim_lg[2] = RST_DIM_LOG2;
		scale_r = RST_SCALE;
		oct_r = RST_OCTAVES;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// shuffled permutation loaded first
		for (int i = 0; i < TBL_DEPTH; i++) shuf[i] = TBL_DW'(i);
		for (int i = TBL_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = shuf[i];
			shuf[i] = shuf[j];
			shuf[j] = tmp;
		end
		for (int i = 0; i < TBL_DEPTH; i++) begin
			r = rand_req(1'b1);
			r.idx = TBL_AW'(i);
			r.val = shuf[i];
			pending_reqs.push_back(r);
			writes_sent++;
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 50;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 50;
				end
				default: begin
					send_idle_pct = 23;
					recv_stall_pct = 23;
				end
			endcase
			for (int g = 0; g < 4; g++) begin
				wait_drain();
				if (ph != 0 || g != 0) begin
					wl = CFG_W'($urandom_range(12));
					hl = CFG_W'($urandom_range(12));
					dl = CFG_W'($urandom_range(12));
					sc = CFG_W'($urandom_range(15));
					oc = CFG_W'($urandom_range(10));
					apb_write(REG_WIDTH, wl);
					apb_write(REG_HEIGHT, hl);
					apb_write(REG_DEPTH, dl);
					apb_write(REG_SCALE, sc);
					apb_write(REG_OCTAVES, oc);
					apb_check(REG_WIDTH, wl);
					apb_check(REG_OCTAVES, oc);
					cfg_groups++;
				end
				for (int i = 0; i < GROUP_ITEMS; i++) begin
					wr = $urandom_range(99) < 6;
					pending_reqs.push_back(rand_req(wr));
					if (wr) writes_sent++;
					else evals_sent++;
				end
			end
		end

		wait_drain();
		$display("covered %0d table writes and %0d texel requests under %0d configurations",
			writes_sent, evals_sent, cfg_groups + 1);
		$display("four idle and stall phases, %0d texels checked", texels_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// File: fractal_perlin_noise_texel.f
design/fpn_pkg.sv
design/fpn_perm_mem.sv
design/fpn_mul.sv
design/fpn_div.sv
design/fractal_perlin_noise_texel.sv
tb/testbench.sv
